// ----- hdl/mmcc_pkg.sv -----
// Shared types, codes and CRC helper functions for the checksum and CRC block.
`default_nettype none

package mmcc_pkg;

  // Check modes as held in the check_mode register; code 7 is unused.
  typedef enum logic [2:0] {
    MODE_SUM8    = 3'd0,
    MODE_WSUM16  = 3'd1,
    MODE_BSUM16  = 3'd2,
    MODE_BSUM32  = 3'd3,
    MODE_CRC8    = 3'd4,
    MODE_CRC16   = 3'd5,
    MODE_CRC32   = 3'd6
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CHECK_MODE       = 3'd0,
    REG_BIG_ENDIAN_WORDS = 3'd1,
    REG_CRC_POLYNOMIAL   = 3'd2,
    REG_CRC_INITIAL      = 3'd3,
    REG_CRC_FINAL_XOR    = 3'd4,
    REG_REFLECT_INPUT    = 3'd5
  } reg_index_t;

  localparam logic [31:0] POLY_RESET = 32'h0000_0007;
  localparam logic [31:0] MASK_SUM8  = 32'h0000_00FF;
  localparam logic [31:0] MASK_SUM16 = 32'h0000_FFFF;

  // Number of unused high bits of the 32-bit datapath for a CRC mode.
  function automatic logic [4:0] crc_pad(input mode_t mode);
    logic [4:0] pad;
    case (mode)
      MODE_CRC8:  pad = 5'd24;
      MODE_CRC16: pad = 5'd16;
      default:    pad = 5'd0;
    endcase
    return pad;
  endfunction

  function automatic logic is_crc(input mode_t mode);
    return (mode == MODE_CRC8) || (mode == MODE_CRC16) || (mode == MODE_CRC32);
  endfunction

  function automatic logic [31:0] mirror32(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[k] = v[31-k];
    end
    return r;
  endfunction

  // Starting value of the CRC register, masked and optionally reflected.
  function automatic logic [31:0] crc_seed(input logic [31:0] init, input logic [4:0] pad,
                                           input logic reflect);
    logic [31:0] mask;
    logic [31:0] s;
    mask = 32'hFFFF_FFFF >> pad;
    s    = init & mask;
    if (reflect) begin
      s = mirror32(s) >> pad;
    end
    return s;
  endfunction

  // One byte through the CRC. Normal mode works left-aligned in 32 bits so
  // the top bit is always bit 31; reflected mode works right-aligned.
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] din,
                                           input logic [31:0] poly, input logic [4:0] pad,
                                           input logic reflect);
    logic [31:0] mask;
    logic [31:0] p;
    logic [31:0] a;
    mask = 32'hFFFF_FFFF >> pad;
    p    = poly & mask;
    a    = acc & mask;
    if (reflect) begin
      p = mirror32(p) >> pad;
      a = a ^ {24'd0, din};
      for (int k = 0; k < 8; k++) begin
        a = a[0] ? ((a >> 1) ^ p) : (a >> 1);
      end
    end else begin
      p = p << pad;
      a = (a << pad) ^ {din, 24'd0};
      for (int k = 0; k < 8; k++) begin
        a = a[31] ? ((a << 1) ^ p) : (a << 1);
      end
      a = a >> pad;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/multi_mode_checksum_crc.sv -----
// Top level of the multi-mode checksum and CRC block.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_ready    data_byte[7:0], last_byte
//   output   out        out_valid / out_ready  check_value[31:0]
//   config   in         cfg_wr_en (no wait)    cfg_index[2:0], cfg_data[31:0]
//
// One byte is taken per cycle unless a waiting result stalls the input. A
// transaction lands in an input register; from there the sum adder or the
// byte-wide CRC network updates the accumulator, and a byte flagged last also
// loads the result register, so a check value passes both register stages.
// Reset clears all configuration registers to their defaults and empties both
// register stages. A waiting result stalls only a following last byte; other
// bytes keep flowing past it into the accumulator.
`default_nettype none

module multi_mode_checksum_crc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      check_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers.
  mmcc_pkg::mode_t check_mode;
  logic            big_endian_words;
  logic [31:0]     crc_polynomial;
  logic [31:0]     crc_initial;
  logic [31:0]     crc_final_xor;
  logic            reflect_input;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode       <= mmcc_pkg::MODE_SUM8;
      big_endian_words <= 1'b0;
      crc_polynomial   <= mmcc_pkg::POLY_RESET;
      crc_initial      <= '0;
      crc_final_xor    <= '0;
      reflect_input    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mmcc_pkg::REG_CHECK_MODE:       check_mode       <= mmcc_pkg::mode_t'(cfg_data[2:0]);
        mmcc_pkg::REG_BIG_ENDIAN_WORDS: big_endian_words <= cfg_data[0];
        mmcc_pkg::REG_CRC_POLYNOMIAL:   crc_polynomial   <= cfg_data;
        mmcc_pkg::REG_CRC_INITIAL:      crc_initial      <= cfg_data;
        mmcc_pkg::REG_CRC_FINAL_XOR:    crc_final_xor    <= cfg_data;
        mmcc_pkg::REG_REFLECT_INPUT:    reflect_input    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;
  logic       advance;

  // A byte moves on unless it is a last byte and a held result is not taken.
  assign advance  = stage_valid && (!stage_last || !out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= data_byte;
      stage_last <= last_byte;
    end
  end

  // Stream state.
  logic [31:0] accumulator;
  logic [7:0]  held_byte;
  logic        pair_phase;
  logic        stream_started;

  logic [31:0] accumulator_next;
  logic [7:0]  held_byte_next;
  logic        pair_phase_next;
  logic        stream_started_next;
  logic [31:0] result_next;

  logic [4:0]  pad;
  logic [31:0] acc_start;
  logic [7:0]  held_start;
  logic        phase_start;
  logic [31:0] word;
  logic [31:0] crc_out;
  logic [31:0] acc_upd;

  always_comb begin
    pad = mmcc_pkg::crc_pad(check_mode);

    // The first byte of a stream starts from zero, or from the CRC seed.
    if (stream_started) begin
      acc_start   = accumulator;
      held_start  = held_byte;
      phase_start = pair_phase;
    end else begin
      acc_start   = mmcc_pkg::is_crc(check_mode)
                    ? mmcc_pkg::crc_seed(crc_initial, pad, reflect_input) : '0;
      held_start  = '0;
      phase_start = 1'b0;
    end

    crc_out = mmcc_pkg::crc_byte(acc_start, stage_byte, crc_polynomial, pad, reflect_input);

    // Word for the pair sum; an odd trailing byte pairs with zero.
    if (phase_start) begin
      word = big_endian_words ? {16'd0, held_start, stage_byte}
                              : {16'd0, stage_byte, held_start};
    end else begin
      word = big_endian_words ? {16'd0, stage_byte, 8'd0} : {24'd0, stage_byte};
    end

    acc_upd         = acc_start;
    held_byte_next  = held_start;
    pair_phase_next = phase_start;
    case (check_mode)
      mmcc_pkg::MODE_WSUM16: begin
        if (phase_start || stage_last) begin
          acc_upd         = acc_start + word;
          held_byte_next  = '0;
          pair_phase_next = 1'b0;
        end else begin
          held_byte_next  = stage_byte;
          pair_phase_next = 1'b1;
        end
      end
      mmcc_pkg::MODE_SUM8,
      mmcc_pkg::MODE_BSUM16,
      mmcc_pkg::MODE_BSUM32: acc_upd = acc_start + {24'd0, stage_byte};
      mmcc_pkg::MODE_CRC8,
      mmcc_pkg::MODE_CRC16,
      mmcc_pkg::MODE_CRC32:  acc_upd = crc_out;
      default: ;
    endcase

    case (check_mode)
      mmcc_pkg::MODE_SUM8:   result_next = acc_upd & mmcc_pkg::MASK_SUM8;
      mmcc_pkg::MODE_WSUM16,
      mmcc_pkg::MODE_BSUM16: result_next = acc_upd & mmcc_pkg::MASK_SUM16;
      mmcc_pkg::MODE_BSUM32: result_next = acc_upd;
      mmcc_pkg::MODE_CRC8,
      mmcc_pkg::MODE_CRC16,
      mmcc_pkg::MODE_CRC32:  result_next = (acc_upd ^ crc_final_xor) & (32'hFFFF_FFFF >> pad);
      default:               result_next = '0;
    endcase

    // The end of a range returns the stream state to zero.
    if (stage_last) begin
      accumulator_next    = '0;
      held_byte_next      = '0;
      pair_phase_next     = 1'b0;
      stream_started_next = 1'b0;
    end else begin
      accumulator_next    = acc_upd;
      stream_started_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      held_byte      <= '0;
      pair_phase     <= 1'b0;
      stream_started <= 1'b0;
    end else if (advance) begin
      accumulator    <= accumulator_next;
      held_byte      <= held_byte_next;
      pair_phase     <= pair_phase_next;
      stream_started <= stream_started_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_last) begin
      check_value <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mmcc_checker.sv -----
// Port-level checker for the checksum and CRC block, bound to the top level.
`default_nettype none

module mmcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] check_value
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(check_value))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The input side stalls only behind a result that waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind multi_mode_checksum_crc mmcc_checker u_mmcc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .check_value (check_value)
);

`default_nettype wire
